// ===== sv/fidalloc_pkg.sv =====
// shared widths, operation codes and status codes of the free id allocator
`default_nettype none

package fidalloc_pkg;

    localparam int NUM_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RESET = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_CHECK   = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== sv/fidalloc_ram.sv =====
// simple dual-port ram with one write port and one registered read port
`default_nettype none

module fidalloc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/free_id_allocator_core.sv =====
// top level of the free id allocator: free number fifo, taken marks and request pipeline
`default_nettype none

// Identifier pool over the numbers 0 .. active_count-1, with active_count capped at POOL_DEPTH.
// Request channel: func and number are taken at a rising edge where start is high
// and busy is low. func selects allocate, check or release.
// Result channel: done is high for exactly one cycle with result_number, is_free
// and status; the receiver cannot stall, so results simply follow requests.
// An accepted request is registered in s1_*, and its result in done and the outputs.
// Throughput: one request every cycle while busy is low, since the free fifo ram and
// the taken-mark ram are each read once and written at most once per request, with
// forwarding covering a write and a read of the same entry in back-to-back requests.
// Configuration: active_count_we writes active_count and restarts the pool.
// After reset and after every active_count write the block runs an init pass over all
// POOL_DEPTH ram entries, one ram entry per cycle, that loads the fifo with 0 .. n-1
// and clears every taken mark; busy stays high through that pass.
// Reset: rst_n is asynchronous active low; active_count returns to 1024.
module free_id_allocator_core #(
    parameter int POOL_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [fidalloc_pkg::FUNC_W-1:0]   func,
    input  wire logic [fidalloc_pkg::NUM_W-1:0]    number,
    input  wire logic                              active_count_we,
    input  wire logic [fidalloc_pkg::COUNT_W-1:0]  active_count,
    output      logic                              done,
    output      logic [fidalloc_pkg::NUM_W-1:0]    result_number,
    output      logic                              is_free,
    output      logic [fidalloc_pkg::STATUS_W-1:0] status
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int LW = (CW > fidalloc_pkg::COUNT_W) ? CW : fidalloc_pkg::COUNT_W;

    function automatic logic [CW-1:0] eff_count(input logic [fidalloc_pkg::COUNT_W-1:0] a);
        logic [LW-1:0] a_ext;
        a_ext = LW'(a);
        return (a_ext > LW'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : a_ext[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == AW'(POOL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] init_tail(input logic [CW-1:0] n);
        return (n == CW'(POOL_DEPTH)) ? '0 : n[AW-1:0];
    endfunction

    logic [fidalloc_pkg::COUNT_W-1:0]  active_count_reg;
    logic [AW-1:0]                     head_reg;
    logic [AW-1:0]                     head_next;
    logic [AW-1:0]                     tail_reg;
    logic [AW-1:0]                     tail_next;
    logic [CW-1:0]                     free_count_reg;
    logic [CW-1:0]                     free_count_next;
    logic                              init_active_reg;
    logic [AW-1:0]                     init_idx_reg;

    logic                              s1_valid_reg;
    logic [fidalloc_pkg::FUNC_W-1:0]   s1_func_reg;
    logic [fidalloc_pkg::NUM_W-1:0]    s1_number_reg;
    logic                              fifo_fwd_hit_reg;
    logic [AW-1:0]                     fifo_fwd_data_reg;
    logic                              mark_fwd_hit_reg;
    logic                              mark_fwd_val_reg;

    logic                              done_reg;
    logic [fidalloc_pkg::NUM_W-1:0]    result_number_reg;
    logic                              is_free_reg;
    logic [fidalloc_pkg::STATUS_W-1:0] status_reg;
    logic [fidalloc_pkg::NUM_W-1:0]    res_number;
    logic                              res_free;
    logic [fidalloc_pkg::STATUS_W-1:0] res_status;

    logic [CW-1:0]                     n_eff;
    logic [CW-1:0]                     n_cfg;
    logic                              accept;
    logic                              in_range;
    logic [AW-1:0]                     s1_addr;
    logic [AW-1:0]                     head_val;
    logic                              taken;

    logic                              pop_en;
    logic                              push_en;
    logic                              mark_set;
    logic                              mark_clr;

    logic                              fifo_we;
    logic [AW-1:0]                     fifo_waddr;
    logic [AW-1:0]                     fifo_wdata;
    logic [AW-1:0]                     fifo_rdata;
    logic                              mark_we;
    logic [AW-1:0]                     mark_waddr;
    logic                              mark_wdata;
    logic                              mark_rdata;
    logic [AW-1:0]                     in_addr;

    assign busy     = init_active_reg | active_count_we;
    assign accept   = start & ~busy;
    assign n_eff    = eff_count(active_count_reg);
    assign n_cfg    = eff_count(active_count);
    assign s1_addr  = AW'(s1_number_reg);
    assign in_addr  = AW'(number);
    assign in_range = LW'(s1_number_reg) < LW'(n_eff);
    assign head_val = fifo_fwd_hit_reg ? fifo_fwd_data_reg : fifo_rdata;
    assign taken    = mark_fwd_hit_reg ? mark_fwd_val_reg : mark_rdata;

    // request evaluation on the registered request and ram read data
    always_comb
    begin
        pop_en     = 1'b0;
        push_en    = 1'b0;
        mark_set   = 1'b0;
        mark_clr   = 1'b0;
        res_number = '0;
        res_free   = 1'b0;
        res_status = fidalloc_pkg::STATUS_OK;
        if (s1_valid_reg)
        begin
            unique case (s1_func_reg)
                fidalloc_pkg::FUNC_ALLOC:
                begin
                    if (free_count_reg == '0)
                    begin
                        res_status = fidalloc_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        pop_en     = 1'b1;
                        mark_set   = 1'b1;
                        res_number = fidalloc_pkg::NUM_W'(head_val);
                    end
                end
                fidalloc_pkg::FUNC_CHECK:
                begin
                    if (!in_range)
                    begin
                        res_status = fidalloc_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        res_free = ~taken;
                    end
                end
                fidalloc_pkg::FUNC_RELEASE:
                begin
                    if (!in_range)
                    begin
                        res_status = fidalloc_pkg::STATUS_RANGE;
                    end
                    else if (taken)
                    begin
                        mark_clr = 1'b1;
                        push_en  = (free_count_reg != CW'(POOL_DEPTH));
                    end
                end
                default:
                begin
                    res_status = fidalloc_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        head_next       = pop_en ? wrap_next(head_reg) : head_reg;
        tail_next       = push_en ? wrap_next(tail_reg) : tail_reg;
        free_count_next = free_count_reg;
        if (pop_en)
        begin
            free_count_next = free_count_reg - 1'b1;
        end
        else if (push_en)
        begin
            free_count_next = free_count_reg + 1'b1;
        end
    end

    // ram write ports shared between the init pass and requests
    always_comb
    begin
        if (init_active_reg)
        begin
            fifo_we    = 1'b1;
            fifo_waddr = init_idx_reg;
            fifo_wdata = init_idx_reg;
            mark_we    = 1'b1;
            mark_waddr = init_idx_reg;
            mark_wdata = 1'b0;
        end
        else
        begin
            fifo_we    = push_en;
            fifo_waddr = tail_reg;
            fifo_wdata = s1_addr;
            mark_we    = mark_set | mark_clr;
            mark_waddr = mark_set ? head_val : s1_addr;
            mark_wdata = mark_set;
        end
    end

    fidalloc_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (AW)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (head_next),
        .rdata (fifo_rdata)
    );

    fidalloc_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (1)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (in_addr),
        .rdata (mark_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= fidalloc_pkg::ACTIVE_COUNT_RESET;
            head_reg         <= '0;
            tail_reg         <= init_tail(eff_count(fidalloc_pkg::ACTIVE_COUNT_RESET));
            free_count_reg   <= eff_count(fidalloc_pkg::ACTIVE_COUNT_RESET);
            init_active_reg  <= 1'b1;
            init_idx_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
            if (active_count_we)
            begin
                active_count_reg <= active_count;
                head_reg         <= '0;
                tail_reg         <= init_tail(n_cfg);
                free_count_reg   <= n_cfg;
                init_active_reg  <= 1'b1;
                init_idx_reg     <= '0;
            end
            else
            begin
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                free_count_reg <= free_count_next;
                if (init_active_reg)
                begin
                    init_idx_reg <= wrap_next(init_idx_reg);
                    if (init_idx_reg == AW'(POOL_DEPTH - 1))
                    begin
                        init_active_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // request, forwarding and result payload
    always_ff @(posedge clk)
    begin
        s1_func_reg       <= func;
        s1_number_reg     <= number;
        fifo_fwd_hit_reg  <= push_en && (tail_reg == head_next);
        fifo_fwd_data_reg <= s1_addr;
        mark_fwd_hit_reg  <= (mark_set | mark_clr) && (mark_waddr == in_addr);
        mark_fwd_val_reg  <= mark_set;
        result_number_reg <= res_number;
        is_free_reg       <= res_free;
        status_reg        <= res_status;
    end

    assign done          = done_reg;
    assign result_number = result_number_reg;
    assign is_free       = is_free_reg;
    assign status        = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= n_eff)
        else $error("free count above pool size");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("request without result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without request");

    a_empty_number: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fidalloc_pkg::STATUS_EMPTY) |-> (result_number == '0 && !is_free))
        else $error("empty pool result carries data");
`endif

endmodule

`default_nettype wire
